// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file mmm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold on every clock edge outside of the disable term.
`define CHK_HOLDS(lbl, clk, dis, prop) \
    lbl: assert property (@(posedge clk) disable iff (dis) prop) \
        else $error("mixer checker: property violated");

// A condition seen on one edge forces a consequence on the next edge.
`define CHK_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("mixer checker: next-cycle property violated");

`endif

// ===== rtl/core/mmm_pkg.sv =====
`default_nettype none

package mmm_pkg;

    localparam int MOTOR_SLOTS = 6;
    localparam int PULSE_W     = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 88;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        FRAME_BI    = 2'd0,
        FRAME_QUADX = 2'd1,
        FRAME_HEX6X = 2'd2,
        FRAME_NONE  = 2'd3
    } t_frame;

    typedef enum logic [2:0] {
        REG_FRAME_TYPE   = 3'd0,
        REG_YAW_REVERSE  = 3'd1,
        REG_MIN_THROTTLE = 3'd2,
        REG_MAX_THROTTLE = 3'd3,
        REG_MIN_COMMAND  = 3'd4,
        REG_MIN_CHECK    = 3'd5,
        REG_MOTOR_STOP   = 3'd6
    } t_reg_idx;

    typedef logic [PULSE_W-1:0] t_pulse;
    typedef logic signed [17:0] t_num;
    typedef logic signed [13:0] t_mot;

    typedef struct packed {
        t_frame frame_type;
        logic   yaw_reverse;
        t_pulse min_throttle;
        t_pulse max_throttle;
        t_pulse min_command;
        t_pulse min_check;
        logic   motor_stop;
    } t_cfg;

    // Front stage output: mix numerators before the hex rescale.
    typedef struct packed {
        t_num [MOTOR_SLOTS-1:0] num;
        t_pulse                 srv_l;
        t_pulse                 srv_r;
        logic                   low_stick;
        logic                   armed;
    } t_stage;

    // Queue entry: raw motor mix, ready for limiting.
    typedef struct packed {
        t_mot [MOTOR_SLOTS-1:0] motor;
        t_pulse                 srv_l;
        t_pulse                 srv_r;
        logic                   low_stick;
        logic                   armed;
    } t_item;

    localparam t_pulse RST_MIN_THROTTLE = 11'd1150;
    localparam t_pulse RST_MAX_THROTTLE = 11'd1850;
    localparam t_pulse RST_MIN_COMMAND  = 11'd1000;
    localparam t_pulse RST_MIN_CHECK    = 11'd1100;

    localparam t_pulse SERVO_MID = 11'd1500;
    localparam t_pulse SERVO_LO  = 11'd1020;
    localparam t_pulse SERVO_HI  = 11'd2000;
    localparam logic [6:0] YAW_LIM_BASE = 7'd100;

    // floor(n/10) = ((n + 30000) * 104858 >> 20) - 3000 for the numerator range.
    localparam logic [16:0] DIV10_MUL   = 17'd104858;
    localparam t_num        DIV10_BIAS  = 18'sd30000;
    localparam t_mot        DIV10_QBIAS = 14'sd3000;
    // floor(x/20) = x * 52429 >> 20 for x below 2^18.
    localparam logic [15:0] DIV20_MUL   = 16'd52429;
    localparam int          RECIP_SHIFT = 20;

    localparam logic signed [1:0] QUAD_W_ROLL  [4] = '{-2'sd1, 2'sd1, 2'sd1, -2'sd1};
    localparam logic signed [1:0] QUAD_W_PITCH [4] = '{-2'sd1, -2'sd1, 2'sd1, 2'sd1};
    localparam logic signed [1:0] QUAD_W_YAW   [4] = '{2'sd1, -2'sd1, 2'sd1, -2'sd1};

    localparam logic signed [1:0] HEX_W_ROLL  [MOTOR_SLOTS] =
        '{-2'sd1, 2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] HEX_W_PITCH [MOTOR_SLOTS] =
        '{-2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd0};
    localparam logic signed [1:0] HEX_W_YAW   [MOTOR_SLOTS] =
        '{2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1};

    // Applies a weight of -1, 0 or +1 to a term.
    function automatic t_num apply_w(input logic signed [1:0] w, input t_num x);
        t_num r;
        if (w == 2'sd1) begin
            r = x;
        end else if (w == -2'sd1) begin
            r = -x;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mmm_front.sv =====
`default_nettype none

module mmm_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire  mmm_pkg::t_cfg                i_cfg,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [mmm_pkg::IN_W-1:0]           i_data,
    output logic                               o_valid,
    input  wire                                i_ready,
    output mmm_pkg::t_item                     o_item
);

    logic            r_a_valid;
    mmm_pkg::t_stage r_a;
    mmm_pkg::t_stage n_a;
    logic            r_b_valid;
    mmm_pkg::t_item  r_b;
    mmm_pkg::t_item  n_b;
    logic            load_a;
    logic            load_b;

    logic [10:0]        thr;
    logic signed [10:0] roll;
    logic signed [10:0] pitch;
    logic signed [10:0] yaw;
    logic signed [9:0]  ystick;
    logic [10:0]        tstick;
    logic signed [11:0] ystick_abs;
    logic signed [11:0] yaw_lim;
    logic signed [11:0] yaw_c;
    logic signed [11:0] yaw_e;
    mmm_pkg::t_num      thr18;
    mmm_pkg::t_num      roll18;
    mmm_pkg::t_num      pitch18;
    mmm_pkg::t_num      yaw18;
    mmm_pkg::t_num      yawr18;
    logic signed [12:0] srv_l_raw;
    logic signed [12:0] srv_r_raw;
    logic [16:0]        div_in  [mmm_pkg::MOTOR_SLOTS];
    logic [33:0]        div_prod [mmm_pkg::MOTOR_SLOTS];

    assign thr    = i_data[10:0];
    assign roll   = $signed(i_data[21:11]);
    assign pitch  = $signed(i_data[32:22]);
    assign yaw    = $signed(i_data[43:33]);
    assign ystick = $signed(i_data[53:44]);
    assign tstick = i_data[64:54];

    // Yaw limit of 100 plus the stick deflection, used by the quad and hex mixes.
    always_comb begin
        ystick_abs = ystick[9] ? -{{2{ystick[9]}}, ystick} : {{2{ystick[9]}}, ystick};
        yaw_lim    = $signed({5'd0, mmm_pkg::YAW_LIM_BASE}) + ystick_abs;
        if ($signed({yaw[10], yaw}) > yaw_lim) begin
            yaw_c = yaw_lim;
        end else if ($signed({yaw[10], yaw}) < -yaw_lim) begin
            yaw_c = -yaw_lim;
        end else begin
            yaw_c = {yaw[10], yaw};
        end
        yaw_e = i_cfg.yaw_reverse ? -yaw_c : yaw_c;
    end

    always_comb begin
        thr18   = $signed({7'd0, thr});
        roll18  = {{7{roll[10]}}, roll};
        pitch18 = {{7{pitch[10]}}, pitch};
        yaw18   = {{6{yaw_e[11]}}, yaw_e};
        yawr18  = {{7{yaw[10]}}, yaw};

        n_a.num = '0;
        case (i_cfg.frame_type)
            mmm_pkg::FRAME_BI: begin
                n_a.num[0] = thr18 + roll18;
                n_a.num[1] = thr18 - roll18;
            end
            mmm_pkg::FRAME_QUADX: begin
                for (int i = 0; i < 4; i++) begin
                    n_a.num[i] = thr18
                        + mmm_pkg::apply_w(mmm_pkg::QUAD_W_ROLL[i], roll18)
                        + mmm_pkg::apply_w(mmm_pkg::QUAD_W_PITCH[i], pitch18)
                        + mmm_pkg::apply_w(mmm_pkg::QUAD_W_YAW[i], yaw18);
                end
            end
            mmm_pkg::FRAME_HEX6X: begin
                // Everything in tenths: 10*thr, 8*roll, 9*pitch, 10*yaw.
                for (int i = 0; i < mmm_pkg::MOTOR_SLOTS; i++) begin
                    n_a.num[i] = (thr18 <<< 3) + (thr18 <<< 1)
                        + mmm_pkg::apply_w(mmm_pkg::HEX_W_ROLL[i], roll18 <<< 3)
                        + mmm_pkg::apply_w(mmm_pkg::HEX_W_PITCH[i],
                                           (pitch18 <<< 3) + pitch18)
                        + mmm_pkg::apply_w(mmm_pkg::HEX_W_YAW[i],
                                           (yaw18 <<< 3) + (yaw18 <<< 1));
                end
            end
            default: begin
                n_a.num = '0;
            end
        endcase

        // Bicopter servo targets use the unlimited yaw.
        srv_l_raw = $signed({2'd0, mmm_pkg::SERVO_MID}) - yawr18[12:0] - pitch18[12:0];
        srv_r_raw = $signed({2'd0, mmm_pkg::SERVO_MID}) - yawr18[12:0] + pitch18[12:0];
        if (srv_l_raw < $signed({2'd0, mmm_pkg::SERVO_LO})) begin
            n_a.srv_l = mmm_pkg::SERVO_LO;
        end else if (srv_l_raw > $signed({2'd0, mmm_pkg::SERVO_HI})) begin
            n_a.srv_l = mmm_pkg::SERVO_HI;
        end else begin
            n_a.srv_l = srv_l_raw[10:0];
        end
        if (srv_r_raw < $signed({2'd0, mmm_pkg::SERVO_LO})) begin
            n_a.srv_r = mmm_pkg::SERVO_LO;
        end else if (srv_r_raw > $signed({2'd0, mmm_pkg::SERVO_HI})) begin
            n_a.srv_r = mmm_pkg::SERVO_HI;
        end else begin
            n_a.srv_r = srv_r_raw[10:0];
        end
        n_a.low_stick = (tstick < i_cfg.min_check);
        n_a.armed     = i_data[65];
    end

    // Second stage: the hex mix is divided by ten with floor.
    always_comb begin
        n_b.srv_l     = r_a.srv_l;
        n_b.srv_r     = r_a.srv_r;
        n_b.low_stick = r_a.low_stick;
        n_b.armed     = r_a.armed;
        for (int i = 0; i < mmm_pkg::MOTOR_SLOTS; i++) begin
            div_in[i]   = 17'($signed(r_a.num[i]) + mmm_pkg::DIV10_BIAS);
            div_prod[i] = 34'(div_in[i]) * 34'(mmm_pkg::DIV10_MUL);
            if (i_cfg.frame_type == mmm_pkg::FRAME_HEX6X) begin
                n_b.motor[i] = $signed(div_prod[i][33:mmm_pkg::RECIP_SHIFT])
                               - mmm_pkg::DIV10_QBIAS;
            end else begin
                n_b.motor[i] = r_a.num[i][13:0];
            end
        end
    end

    assign load_b  = r_a_valid && (!r_b_valid || i_ready);
    assign o_ready = !r_a_valid || load_b;
    assign load_a  = i_valid && o_ready;
    assign o_valid = r_b_valid;
    assign o_item  = r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (load_a) begin
                r_a_valid <= 1'b1;
            end else if (load_b) begin
                r_a_valid <= 1'b0;
            end
            if (load_b) begin
                r_b_valid <= 1'b1;
            end else if (i_ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a <= n_a;
        end
        if (load_b) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mmm_fifo.sv =====
`default_nettype none

module mmm_fifo #(
    parameter int DEPTH = mmm_pkg::QUEUE_DEPTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_ready,
    input  wire  mmm_pkg::t_item i_item,
    output logic                 o_valid,
    input  wire                  i_pop,
    output mmm_pkg::t_item       o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmm_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mmm_back.sv =====
`default_nettype none

module mmm_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  mmm_pkg::t_cfg          i_cfg,
    input  wire                          i_valid,
    output logic                         o_pop,
    input  wire  mmm_pkg::t_item         i_item,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [mmm_pkg::OUT_W-1:0]    o_data
);

    logic                        r_valid;
    logic [mmm_pkg::OUT_W-1:0]   r_data;
    logic [mmm_pkg::OUT_W-1:0]   n_data;
    mmm_pkg::t_pulse             r_srv_l_prev;
    mmm_pkg::t_pulse             r_srv_r_prev;
    mmm_pkg::t_pulse             n_srv_l;
    mmm_pkg::t_pulse             n_srv_r;

    mmm_pkg::t_mot      mx01;
    mmm_pkg::t_mot      mx23;
    mmm_pkg::t_mot      mx45;
    mmm_pkg::t_mot      mx03;
    mmm_pkg::t_mot      mx05;
    mmm_pkg::t_mot      mx;
    logic signed [14:0] hi;
    logic signed [14:0] lo;
    logic signed [14:0] excess;
    logic               over;
    logic signed [14:0] shifted [mmm_pkg::MOTOR_SLOTS];
    mmm_pkg::t_pulse    mot [mmm_pkg::MOTOR_SLOTS];
    int unsigned        nused;
    logic [15:0]        acc_l;
    logic [15:0]        acc_r;
    logic [31:0]        prod_l;
    logic [31:0]        prod_r;
    logic               is_bi;

    function automatic mmm_pkg::t_mot max2(input mmm_pkg::t_mot a, input mmm_pkg::t_mot b);
        return (a > b) ? a : b;
    endfunction

    assign is_bi = (i_cfg.frame_type == mmm_pkg::FRAME_BI);
    assign o_pop = i_valid && (!r_valid || i_ready);

    always_comb begin
        mx01 = max2(i_item.motor[0], i_item.motor[1]);
        mx23 = max2(i_item.motor[2], i_item.motor[3]);
        mx45 = max2(i_item.motor[4], i_item.motor[5]);
        mx03 = max2(mx01, mx23);
        mx05 = max2(mx03, mx45);
        case (i_cfg.frame_type)
            mmm_pkg::FRAME_BI: begin
                mx    = mx01;
                nused = 2;
            end
            mmm_pkg::FRAME_QUADX: begin
                mx    = mx03;
                nused = 4;
            end
            mmm_pkg::FRAME_HEX6X: begin
                mx    = mx05;
                nused = 6;
            end
            default: begin
                mx    = mx01;
                nused = 0;
            end
        endcase

        hi     = $signed({4'd0, i_cfg.max_throttle});
        lo     = $signed({4'd0, i_cfg.min_throttle});
        over   = ($signed({mx[13], mx}) > hi);
        excess = {mx[13], mx} - hi;

        for (int i = 0; i < mmm_pkg::MOTOR_SLOTS; i++) begin
            shifted[i] = over ? ({i_item.motor[i][13], i_item.motor[i]} - excess)
                              : {i_item.motor[i][13], i_item.motor[i]};
            // The lower limit wins when the limits cross.
            if (shifted[i] < lo) begin
                mot[i] = i_cfg.min_throttle;
            end else if (shifted[i] > hi) begin
                mot[i] = i_cfg.max_throttle;
            end else begin
                mot[i] = shifted[i][10:0];
            end
            if (i_item.low_stick) begin
                mot[i] = i_cfg.motor_stop ? i_cfg.min_command : i_cfg.min_throttle;
            end
            if (!i_item.armed || (i >= nused)) begin
                mot[i] = i_cfg.min_command;
            end
        end
    end

    // Servo low-pass: floor((19*prev + target) / 20).
    always_comb begin
        acc_l  = ({5'd0, r_srv_l_prev} << 4) + ({5'd0, r_srv_l_prev} << 1)
                 + {5'd0, r_srv_l_prev} + {5'd0, i_item.srv_l};
        acc_r  = ({5'd0, r_srv_r_prev} << 4) + ({5'd0, r_srv_r_prev} << 1)
                 + {5'd0, r_srv_r_prev} + {5'd0, i_item.srv_r};
        prod_l = 32'(acc_l) * 32'(mmm_pkg::DIV20_MUL);
        prod_r = 32'(acc_r) * 32'(mmm_pkg::DIV20_MUL);
        n_srv_l = prod_l[mmm_pkg::RECIP_SHIFT +: mmm_pkg::PULSE_W];
        n_srv_r = prod_r[mmm_pkg::RECIP_SHIFT +: mmm_pkg::PULSE_W];
    end

    always_comb begin
        for (int i = 0; i < mmm_pkg::MOTOR_SLOTS; i++) begin
            n_data[i*mmm_pkg::PULSE_W +: mmm_pkg::PULSE_W] = mot[i];
        end
        n_data[mmm_pkg::MOTOR_SLOTS*mmm_pkg::PULSE_W +: mmm_pkg::PULSE_W] =
            is_bi ? n_srv_l : mmm_pkg::SERVO_MID;
        n_data[(mmm_pkg::MOTOR_SLOTS+1)*mmm_pkg::PULSE_W +: mmm_pkg::PULSE_W] =
            is_bi ? n_srv_r : mmm_pkg::SERVO_MID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_srv_l_prev <= '0;
            r_srv_r_prev <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (o_pop && is_bi) begin
                r_srv_l_prev <= n_srv_l;
                r_srv_r_prev <= n_srv_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/multirotor_motor_mixer_top.sv =====
// A result passes through two front stages, one queue slot and one output register before it
// is offered on the output stream, and waits longer while the output stalls.
// Throughput: one item per cycle; the front keeps accepting until the queue and its two stages fill.
// Reset: synchronous, active low; registers return to their documented defaults, servo
// history clears to zero and all stages, queue and output empty at once, with no clearing pass.
`default_nettype none

module multirotor_motor_mixer_top #(
    parameter int QUEUE_DEPTH = mmm_pkg::QUEUE_DEPTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Configuration port.
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [mmm_pkg::ADDR_W-1:0]       paddr,
    input  wire  [mmm_pkg::DATA_W-1:0]       pwdata,
    output logic [mmm_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    // Input items.
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0: throttle_command[10:0], roll_pid[10:0], pitch_pid[10:0], yaw_pid[10:0],
    // yaw_stick[9:0], throttle_stick[10:0], armed, then six zero bits.
    input  wire  [mmm_pkg::IN_W-1:0]         s_axis_tdata,
    // Result items.
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // From bit 0: motor_0 .. motor_5, servo_left, servo_right, eleven bits each.
    output logic [mmm_pkg::OUT_W-1:0]        m_axis_tdata
);

    // The block is split into a front that accepts items, limits yaw and forms the
    // per-frame mix, a short queue, and a back that applies the throttle ceiling,
    // clamps, the stick and arming overrides, and runs the bicopter servo filter.
    // The back owns the servo history so items update it strictly in order.

    mmm_pkg::t_cfg  r_cfg;
    mmm_pkg::t_item front_item;
    mmm_pkg::t_item queue_item;
    logic           front_valid;
    logic           queue_ready;
    logic           queue_valid;
    logic           back_pop;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes land on the access cycle; addresses past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_type   <= mmm_pkg::FRAME_QUADX;
            r_cfg.yaw_reverse  <= 1'b0;
            r_cfg.min_throttle <= mmm_pkg::RST_MIN_THROTTLE;
            r_cfg.max_throttle <= mmm_pkg::RST_MAX_THROTTLE;
            r_cfg.min_command  <= mmm_pkg::RST_MIN_COMMAND;
            r_cfg.min_check    <= mmm_pkg::RST_MIN_CHECK;
            r_cfg.motor_stop   <= 1'b0;
        end else if (cfg_write) begin
            case (mmm_pkg::t_reg_idx'(paddr[4:2]))
                mmm_pkg::REG_FRAME_TYPE:   r_cfg.frame_type   <= mmm_pkg::t_frame'(pwdata[1:0]);
                mmm_pkg::REG_YAW_REVERSE:  r_cfg.yaw_reverse  <= pwdata[0];
                mmm_pkg::REG_MIN_THROTTLE: r_cfg.min_throttle <= pwdata[10:0];
                mmm_pkg::REG_MAX_THROTTLE: r_cfg.max_throttle <= pwdata[10:0];
                mmm_pkg::REG_MIN_COMMAND:  r_cfg.min_command  <= pwdata[10:0];
                mmm_pkg::REG_MIN_CHECK:    r_cfg.min_check    <= pwdata[10:0];
                mmm_pkg::REG_MOTOR_STOP:   r_cfg.motor_stop   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Read-back of the current register values.
    always_comb begin
        case (mmm_pkg::t_reg_idx'(paddr[4:2]))
            mmm_pkg::REG_FRAME_TYPE:   prdata = 32'(r_cfg.frame_type);
            mmm_pkg::REG_YAW_REVERSE:  prdata = 32'(r_cfg.yaw_reverse);
            mmm_pkg::REG_MIN_THROTTLE: prdata = 32'(r_cfg.min_throttle);
            mmm_pkg::REG_MAX_THROTTLE: prdata = 32'(r_cfg.max_throttle);
            mmm_pkg::REG_MIN_COMMAND:  prdata = 32'(r_cfg.min_command);
            mmm_pkg::REG_MIN_CHECK:    prdata = 32'(r_cfg.min_check);
            mmm_pkg::REG_MOTOR_STOP:   prdata = 32'(r_cfg.motor_stop);
            default:                   prdata = '0;
        endcase
    end

    mmm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (queue_ready),
        .o_item  (front_item)
    );

    mmm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_item  (queue_item)
    );

    mmm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_pop   (back_pop),
        .i_item  (queue_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mmm_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mmm_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            psel,
    input wire                            penable,
    input wire                            pwrite,
    input wire [mmm_pkg::ADDR_W-1:0]      paddr,
    input wire [mmm_pkg::DATA_W-1:0]      pwdata,
    input wire                            pready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [mmm_pkg::OUT_W-1:0]       m_axis_tdata
);

    // Shadow copies of the registers that decide fixed output slots.
    mmm_pkg::t_frame r_frame;
    mmm_pkg::t_pulse r_min_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame   <= mmm_pkg::FRAME_QUADX;
            r_min_cmd <= mmm_pkg::RST_MIN_COMMAND;
        end else if (psel && penable && pwrite && pready) begin
            case (mmm_pkg::t_reg_idx'(paddr[4:2]))
                mmm_pkg::REG_FRAME_TYPE:  r_frame   <= mmm_pkg::t_frame'(pwdata[1:0]);
                mmm_pkg::REG_MIN_COMMAND: r_min_cmd <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    `CHK_NEXT(a_out_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready,
              m_axis_tvalid && $stable(m_axis_tdata))

    `CHK_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid)

    `CHK_HOLDS(a_servo_mid, i_clk, !i_rst_n,
               (m_axis_tvalid && r_frame != mmm_pkg::FRAME_BI) |->
               (m_axis_tdata[76:66] == mmm_pkg::SERVO_MID
                && m_axis_tdata[87:77] == mmm_pkg::SERVO_MID))

    `CHK_HOLDS(a_quad_unused, i_clk, !i_rst_n,
               (m_axis_tvalid && r_frame == mmm_pkg::FRAME_QUADX) |->
               (m_axis_tdata[54:44] == r_min_cmd && m_axis_tdata[65:55] == r_min_cmd))

endmodule

bind multirotor_motor_mixer_top mmm_checker u_mmm_checker (.*);

`default_nettype wire
